>>> rtl/mfsc_pkg.sv
// ----------------------------------------------------------------------------
// mfsc_pkg
// Shared types and constants for the MIDI file structure checker: phase
// codes, verdict reason codes, request and result records, and the fixed
// tags and byte positions of the file layout.
// ----------------------------------------------------------------------------
package mfsc_pkg;

  // Field widths fixed by the file layout.
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned TRACKS_W = 16;
  localparam int unsigned IDX_W    = 4;

  // Layout constants.
  localparam logic [SIZE_W-1:0] MIN_FILE_SIZE = 31'h1E;
  localparam logic [SIZE_W-1:0] TRK_HDR_BYTES = 31'h08;
  localparam logic [31:0]       MTHD_TAG      = 32'h4D546864;
  localparam logic [31:0]       MTRK_TAG      = 32'h4D54726B;
  localparam logic [31:0]       HDR_LEN       = 32'h00000006;
  localparam logic [15:0]       MAX_FORMAT    = 16'h0002;
  localparam logic [23:0]       EOT_MARK      = 24'hFF2F00;

  // Byte positions (last byte of each field) within a chunk header.
  localparam logic [IDX_W-1:0] POS_TAG_LAST  = 4'd3;
  localparam logic [IDX_W-1:0] POS_LEN_LAST  = 4'd7;
  localparam logic [IDX_W-1:0] POS_FMT_LAST  = 4'd9;
  localparam logic [IDX_W-1:0] POS_NTRK_LAST = 4'd11;
  localparam logic [IDX_W-1:0] POS_HDR_LAST  = 4'd13;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HDR    = 5'b00010,
    PH_TRKHDR = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    RSN_OK         = 4'd0,
    RSN_SHORT      = 4'd1,
    RSN_BAD_MTHD   = 4'd2,
    RSN_BAD_HLEN   = 4'd3,
    RSN_BAD_FORMAT = 4'd4,
    RSN_NO_TRACKS  = 4'd5,
    RSN_NO_ROOM    = 4'd6,
    RSN_BAD_MTRK   = 4'd7,
    RSN_BAD_TLEN   = 4'd8,
    RSN_NO_EOT     = 4'd9,
    RSN_OVERRUN    = 4'd10
  } reason_t;

  // One input request.
  typedef struct packed {
    logic              first;
    logic [7:0]        data_byte;
    logic [SIZE_W-1:0] total_size;
  } item_t;

  // One verdict, with its valid flag.
  typedef struct packed {
    logic              vld;
    logic              accepted;
    reason_t           reason;
    logic [SIZE_W-1:0] file_size;
  } result_t;

endpackage

>>> rtl/mfsc_in_stage.sv
// ----------------------------------------------------------------------------
// mfsc_in_stage
// Input register. Captures one request and holds it until the checker
// consumes it; a new request is taken in the same cycle as one leaves.
// ----------------------------------------------------------------------------
module mfsc_in_stage
  import mfsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Stall only while a held request cannot move on.
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> rtl/mfsc_checker.sv
// ----------------------------------------------------------------------------
// mfsc_checker
// Structure checking state and its per-byte update. Each byte advances
// the phase, the byte position, the remaining and consumed byte counts and
// a four-byte shift window, and may produce the buffer's one verdict.
// ----------------------------------------------------------------------------
module mfsc_checker
  import mfsc_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  localparam int unsigned TL_W = LENGTH_BITS - 1;

  phase_t              phase_r,    phase_nxt;
  logic [IDX_W-1:0]    idx_r,      idx_nxt;
  logic [SIZE_W-1:0]   rem_r,      rem_nxt;
  logic [TRACKS_W-1:0] tracks_r,   tracks_nxt;
  logic [TL_W-1:0]     tleft_r,    tleft_nxt;
  logic [31:0]         shift_r,    shift_nxt;
  logic [SIZE_W-1:0]   cons_r,     cons_nxt;

  phase_t              ph_b;
  logic [IDX_W-1:0]    idx_b;
  logic [SIZE_W-1:0]   rem_b;
  logic [TRACKS_W-1:0] tracks_b;
  logic [SIZE_W-1:0]   cons_b;
  logic [31:0]         shift_b;
  logic [31:0]         shift_new;
  logic [SIZE_W-1:0]   rem_new;
  logic [SIZE_W-1:0]   cons_new;
  logic [TL_W-1:0]     tleft_dec;
  logic [TRACKS_W-1:0] tracks_dec;
  logic                active;
  logic                short_buf;
  logic                room_short;
  logic                len_hi_bad;
  logic                len_gt_room;
  logic                len_gt_rem;
  logic                fail;
  logic                pass;
  reason_t             fail_reason;

  // A first byte restarts from cleared state; otherwise carry on.
  assign ph_b     = item.first ? PH_HDR : phase_r;
  assign idx_b    = item.first ? '0 : idx_r;
  assign rem_b    = item.first ? item.total_size : rem_r;
  assign tracks_b = item.first ? '0 : tracks_r;
  assign cons_b   = item.first ? '0 : cons_r;
  assign shift_b  = item.first ? '0 : shift_r;

  assign shift_new  = {shift_b[23:0], item.data_byte};
  assign rem_new    = rem_b - 1'b1;
  assign cons_new   = cons_b + 1'b1;
  assign tleft_dec  = tleft_r - 1'b1;
  assign tracks_dec = tracks_r - 1'b1;

  assign active    = item.first || (phase_r == PH_HDR) || (phase_r == PH_TRKHDR) ||
                     (phase_r == PH_BODY);
  assign short_buf = item.first && (item.total_size < MIN_FILE_SIZE);
  assign room_short = rem_new < TRK_HDR_BYTES;

  // Track length checks: high bits, room before the header, room after it.
  assign len_hi_bad  = (shift_new >> (LENGTH_BITS - 1)) != 32'd0;
  assign len_gt_room = {1'b0, shift_new} > ({2'b00, rem_new} + 33'd8);
  assign len_gt_rem  = shift_new > {1'b0, rem_new};

  // Next state and verdict for one byte.
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    rem_nxt     = rem_r;
    tracks_nxt  = tracks_r;
    tleft_nxt   = tleft_r;
    shift_nxt   = shift_r;
    cons_nxt    = cons_r;
    fail        = 1'b0;
    pass        = 1'b0;
    fail_reason = RSN_OK;

    if (fire && short_buf) begin
      fail        = 1'b1;
      fail_reason = RSN_SHORT;
      idx_nxt     = '0;
      rem_nxt     = '0;
      tracks_nxt  = '0;
      tleft_nxt   = '0;
      shift_nxt   = '0;
      cons_nxt    = '0;
    end else if (fire && active) begin
      phase_nxt  = ph_b;
      idx_nxt    = idx_b;
      rem_nxt    = rem_new;
      tracks_nxt = tracks_b;
      shift_nxt  = shift_new;
      cons_nxt   = cons_new;

      unique case (ph_b)
        PH_HDR: begin
          if (idx_b == POS_TAG_LAST && shift_new != MTHD_TAG) begin
            fail        = 1'b1;
            fail_reason = RSN_BAD_MTHD;
          end else if (idx_b == POS_LEN_LAST && shift_new != HDR_LEN) begin
            fail        = 1'b1;
            fail_reason = RSN_BAD_HLEN;
          end else if (idx_b == POS_FMT_LAST && shift_new[15:0] > MAX_FORMAT) begin
            fail        = 1'b1;
            fail_reason = RSN_BAD_FORMAT;
          end else if (idx_b == POS_NTRK_LAST && shift_new[15:0] == '0) begin
            fail        = 1'b1;
            fail_reason = RSN_NO_TRACKS;
          end else if (idx_b == POS_HDR_LAST) begin
            if (room_short) begin
              fail        = 1'b1;
              fail_reason = RSN_NO_ROOM;
            end else begin
              phase_nxt = PH_TRKHDR;
              idx_nxt   = '0;
            end
          end else begin
            idx_nxt = idx_b + 1'b1;
            if (idx_b == POS_NTRK_LAST) begin
              tracks_nxt = shift_new[TRACKS_W-1:0];
            end
          end
        end
        PH_TRKHDR: begin
          if (idx_b == POS_TAG_LAST && shift_new != MTRK_TAG) begin
            fail        = 1'b1;
            fail_reason = RSN_BAD_MTRK;
          end else if (idx_b == POS_LEN_LAST) begin
            if (shift_new == '0 || len_hi_bad || len_gt_room) begin
              fail        = 1'b1;
              fail_reason = RSN_BAD_TLEN;
            end else if (len_gt_rem) begin
              fail        = 1'b1;
              fail_reason = RSN_OVERRUN;
            end else begin
              tleft_nxt = shift_new[TL_W-1:0];
              phase_nxt = PH_BODY;
              idx_nxt   = '0;
            end
          end else begin
            idx_nxt = idx_b + 1'b1;
          end
        end
        PH_BODY: begin
          tleft_nxt = tleft_dec;
          if (tleft_dec == '0) begin
            if (shift_new[23:0] != EOT_MARK) begin
              fail        = 1'b1;
              fail_reason = RSN_NO_EOT;
            end else begin
              tracks_nxt = tracks_dec;
              if (tracks_dec == '0) begin
                pass = 1'b1;
              end else if (room_short) begin
                fail        = 1'b1;
                fail_reason = RSN_NO_ROOM;
              end else begin
                phase_nxt = PH_TRKHDR;
                idx_nxt   = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (fail || pass) begin
      phase_nxt = PH_DONE;
    end

    res.vld       = fail || pass;
    res.accepted  = pass;
    res.reason    = pass ? RSN_OK : fail_reason;
    res.file_size = pass ? cons_new : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      idx_r    <= '0;
      rem_r    <= '0;
      tracks_r <= '0;
      tleft_r  <= '0;
      shift_r  <= '0;
      cons_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      rem_r    <= rem_nxt;
      tracks_r <= tracks_nxt;
      tleft_r  <= tleft_nxt;
      shift_r  <= shift_nxt;
      cons_r   <= cons_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Every verdict closes the buffer.
  a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.vld |=> phase_r == PH_DONE)
    else $error("verdict given without closing the buffer");

  // A track body in progress always has bytes left to read.
  a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> tleft_r != '0)
    else $error("track body phase with no bytes left");

  // The header walk never runs past its last byte.
  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HDR |-> idx_r <= POS_HDR_LAST)
    else $error("header byte position out of range");
`endif

endmodule

>>> rtl/mfsc_out_stage.sv
// ----------------------------------------------------------------------------
// mfsc_out_stage
// Result register. Holds a verdict until the receiver takes it and tells
// the rest of the pipeline when it may move on.
// ----------------------------------------------------------------------------
module mfsc_out_stage
  import mfsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s1_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  // The register is free when empty or being read this cycle.
  assign advance = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s1_valid && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/midi_file_structure_check_unit.sv
// ----------------------------------------------------------------------------
// midi_file_structure_check_unit
// Checks the chunk structure of a standard MIDI file streamed one byte a
// request, and gives one verdict per buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one buffer byte per request. Set
//   in_first on the first byte of a buffer and give its length on
//   in_total_size there; in_first restarts checking at any time.
//   Result channel (out_valid / out_stall): one request per buffer carrying
//   out_accepted, out_reason and out_file_size (zero unless accepted).
//   Bytes after a verdict, or without a buffer, produce nothing.
//   A verdict passes from the deciding byte through the input register, then
//   the result register, and waits there until the receiver takes it.
//   Throughput: one byte per cycle when no verdict is stalled; the per-byte
//   update is a single pass of counter and compare logic between the registers.
//   Reset (rst_n low, synchronous) empties both registers and leaves the
//   checker idle, waiting for a first byte.
//   While the receiver stalls a waiting verdict, the input register still
//   accepts a byte if it is empty; further bytes are then stalled.
// ----------------------------------------------------------------------------
module midi_file_structure_check_unit
  import mfsc_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_first,
  input  logic [7:0]        in_data_byte,
  input  logic [SIZE_W-1:0] in_total_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic [3:0]        out_reason,
  output logic [SIZE_W-1:0] out_file_size
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  logic    fire;
  result_t res;
  result_t out_res;

  assign in_item.first      = in_first;
  assign in_item.data_byte  = in_data_byte;
  assign in_item.total_size = in_total_size;

  // Input register.
  mfsc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // The held byte is processed when the result register can take it.
  assign fire = s1_valid && advance;

  mfsc_checker #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item),
    .res   (res)
  );

  // Result register.
  mfsc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_accepted  = out_res.accepted;
  assign out_reason    = out_res.reason;
  assign out_file_size = out_res.file_size;

`ifndef ASSERT_OFF
  // The input side stalls only while a byte is held.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");
`endif

endmodule
